// File: rtl/mfb_pkg.sv
package mfb_pkg;

    // Default storage geometry of the frame store.
    localparam int FB_WORD_BITS_DEF = 32;
    localparam int FB_WORDS_DEF     = 256;

    // Field and register widths.
    localparam int MODE_W     = 3;
    localparam int COORD_W    = 8;
    localparam int W_W        = 8;
    localparam int H_W        = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Largest active display.
    localparam logic [W_W-1:0] MAX_W = 8'd128;
    localparam logic [H_W-1:0] MAX_H = 7'd64;

    // Clamped on-screen coordinates and the linear pixel index.
    localparam int X_W   = 7;
    localparam int Y_W   = 6;
    localparam int IDX_W = $clog2(128 * 64);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXEL  = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_RECT   = 3'd2,
        MODE_FILLED = 3'd3,
        MODE_FILL   = 3'd4,
        MODE_READ   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        EDGE_TOP,
        EDGE_LEFT,
        EDGE_RIGHT,
        EDGE_BOTTOM
    } t_edge;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SEG,
        T_WAIT,
        T_FILL,
        T_FILLW,
        T_RESP
    } t_top_state;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_ISSUE,
        LS_WAIT
    } t_ls_state;

    typedef enum logic [2:0] {
        PX_SWEEP,
        PX_IDLE,
        PX_IDX,
        PX_MUL,
        PX_REM,
        PX_COR,
        PX_WR
    } t_px_state;

    // One pixel access: write ink, or read when rd is set.
    typedef struct packed {
        logic           valid;
        logic           rd;
        logic           ink;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_pix_req;

    typedef struct packed {
        logic ready;
        logic done;
        logic rd_bit;
    } t_pix_rsp;

    // Whole-store sweep that writes every word with the ink.
    typedef struct packed {
        logic valid;
        logic ink;
    } t_sweep_req;

    typedef struct packed {
        logic           valid;
        logic           rd;
        logic           ink;
        logic [X_W-1:0] x0;
        logic [Y_W-1:0] y0;
        logic [X_W-1:0] x1;
        logic [Y_W-1:0] y1;
    } t_seg_req;

    typedef struct packed {
        logic ready;
        logic done;
        logic rd_bit;
    } t_seg_rsp;

endpackage

// File: rtl/mfb_req_if.sv
interface mfb_req_if;

    logic                          valid;
    logic                          ready;
    logic [mfb_pkg::MODE_W-1:0]    mode;
    logic [mfb_pkg::COORD_W-1:0]   x_start;
    logic [mfb_pkg::COORD_W-1:0]   y_start;
    logic [mfb_pkg::COORD_W-1:0]   x_end;
    logic [mfb_pkg::COORD_W-1:0]   y_end;
    logic [mfb_pkg::COORD_W-1:0]   rect_width;
    logic [mfb_pkg::COORD_W-1:0]   rect_height;
    logic                          ink;

    modport source (
        output valid, mode, x_start, y_start, x_end, y_end, rect_width, rect_height, ink,
        input  ready
    );

    modport sink (
        input  valid, mode, x_start, y_start, x_end, y_end, rect_width, rect_height, ink,
        output ready
    );

endinterface

// File: rtl/mfb_rsp_if.sv
interface mfb_rsp_if;

    logic valid;
    logic ready;
    logic pixel_value;
    logic status;

    modport source (
        output valid, pixel_value, status,
        input  ready
    );

    modport sink (
        input  valid, pixel_value, status,
        output ready
    );

endinterface

// File: rtl/mono_framebuffer_line_rect_engine.sv
// Each request becomes segments for the line stepper: a pixel write or read or a line is one,
// an outline has four segments and a filled rectangle one per row. Fill screen is one sweep
// of the store, and a request that draws nothing goes straight to its result. A result waits
// for the output register to empty before it is loaded. Every pixel access goes through the
// shared pixel unit; a new request is taken from the cycle after a result is loaded.
// Reset is synchronous and active low; a clearing pass then zeroes the store.
module mono_framebuffer_line_rect_engine #(
    parameter int FB_WORD_BITS = mfb_pkg::FB_WORD_BITS_DEF,
    parameter int FB_WORDS     = mfb_pkg::FB_WORDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mfb_req_if.sink                         i_req,
    mfb_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [mfb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mfb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int X_W     = mfb_pkg::X_W;
    localparam int Y_W     = mfb_pkg::Y_W;
    localparam int W_W     = mfb_pkg::W_W;
    localparam int H_W     = mfb_pkg::H_W;
    localparam int COORD_W = mfb_pkg::COORD_W;

    // Clamp a column to the last column of the display.
    function automatic logic [X_W-1:0] clamp_x(input logic [COORD_W-1:0] v,
                                               input logic [W_W-1:0] w);
        logic [W_W-1:0] wm1;
        wm1 = w - W_W'(1);
        return (v >= w) ? wm1[X_W-1:0] : v[X_W-1:0];
    endfunction

    // Clamp a row to the last row of the display.
    function automatic logic [Y_W-1:0] clamp_y(input logic [COORD_W-1:0] v,
                                               input logic [H_W-1:0] h);
        logic [H_W-1:0] hm1;
        hm1 = h - H_W'(1);
        return (v >= COORD_W'(h)) ? hm1[Y_W-1:0] : v[Y_W-1:0];
    endfunction

    mfb_pkg::t_top_state r_state, n_state;

    // The effective display size is kept already limited to its legal range, so the
    // datapath never sees a width or height of zero or beyond the largest panel.
    logic [W_W-1:0] r_eff_w, n_eff_w;
    logic [H_W-1:0] r_eff_h, n_eff_h;

    mfb_pkg::t_mode r_mode, n_mode;
    mfb_pkg::t_edge r_part, n_part;
    logic           r_ink, n_ink;
    logic [X_W-1:0] r_ax, n_ax;
    logic [Y_W-1:0] r_ay, n_ay;
    logic [X_W-1:0] r_bx, n_bx;
    logic [Y_W-1:0] r_by, n_by;
    logic [Y_W-1:0] r_row, n_row;
    logic           r_pix, n_pix;
    logic           r_status, n_status;

    logic r_out_valid, n_out_valid;
    logic r_out_pix, n_out_pix;
    logic r_out_status, n_out_status;

    mfb_pkg::t_seg_req   seg_req;
    mfb_pkg::t_seg_rsp   seg_rsp;
    mfb_pkg::t_pix_req   pix_req;
    mfb_pkg::t_pix_rsp   pix_rsp;
    mfb_pkg::t_sweep_req sweep_req;

    logic               req_fire;
    logic               off_screen;
    logic [X_W-1:0]     cx0;
    logic [Y_W-1:0]     cy0;
    logic [X_W-1:0]     cx1;
    logic [Y_W-1:0]     cy1;
    logic [W_W:0]       sum_x;
    logic [W_W:0]       sum_y;
    logic [W_W:0]       sum_x_m1;
    logic [W_W:0]       sum_y_m1;
    logic [W_W-1:0]     ew_m1;
    logic [H_W-1:0]     eh_m1;
    logic [X_W-1:0]     rx1;
    logic [Y_W-1:0]     ry1;
    logic [H_W-1:0]     cfg_h;

    assign i_req.ready = (r_state == mfb_pkg::T_IDLE) && pix_rsp.ready;
    assign req_fire    = i_req.valid && i_req.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.pixel_value = r_out_pix;
    assign o_rsp.status      = r_out_status;

    // Single pixel commands test the raw coordinates against the display.
    assign off_screen = (i_req.x_start >= r_eff_w) || (i_req.y_start >= COORD_W'(r_eff_h));

    // Line endpoints and the rectangle origin clamp to the last column and row.
    assign cx0 = clamp_x(i_req.x_start, r_eff_w);
    assign cy0 = clamp_y(i_req.y_start, r_eff_h);
    assign cx1 = clamp_x(i_req.x_end, r_eff_w);
    assign cy1 = clamp_y(i_req.y_end, r_eff_h);

    // The far rectangle corner is clipped at the display edge.
    assign sum_x    = (W_W + 1)'(cx0) + (W_W + 1)'(i_req.rect_width);
    assign sum_y    = (W_W + 1)'(cy0) + (W_W + 1)'(i_req.rect_height);
    assign sum_x_m1 = sum_x - (W_W + 1)'(1);
    assign sum_y_m1 = sum_y - (W_W + 1)'(1);
    assign ew_m1    = r_eff_w - W_W'(1);
    assign eh_m1    = r_eff_h - H_W'(1);
    assign rx1      = (sum_x > (W_W + 1)'(r_eff_w)) ? ew_m1[X_W-1:0] : sum_x_m1[X_W-1:0];
    assign ry1      = (sum_y > (W_W + 1)'(r_eff_h)) ? eh_m1[Y_W-1:0] : sum_y_m1[Y_W-1:0];

    assign cfg_h = i_cfg_data[H_W-1:0];

    // Segment handed to the line stepper. An outline is its top, left, right and bottom
    // edges in turn, a filled rectangle one horizontal span per row, and every other
    // command one segment between the stored endpoints. A single pixel is a segment of length one.
    always_comb begin
        seg_req.valid = (r_state == mfb_pkg::T_SEG);
        seg_req.rd    = (r_mode == mfb_pkg::MODE_READ);
        seg_req.ink   = r_ink;
        seg_req.x0    = r_ax;
        seg_req.y0    = r_ay;
        seg_req.x1    = r_bx;
        seg_req.y1    = r_by;
        case (r_mode)
            mfb_pkg::MODE_RECT: begin
                case (r_part)
                    mfb_pkg::EDGE_TOP: begin
                        seg_req.y1 = r_ay;
                    end
                    mfb_pkg::EDGE_LEFT: begin
                        seg_req.x1 = r_ax;
                    end
                    mfb_pkg::EDGE_RIGHT: begin
                        seg_req.x0 = r_bx;
                    end
                    default: begin
                        seg_req.y0 = r_by;
                    end
                endcase
            end
            mfb_pkg::MODE_FILLED: begin
                seg_req.y0 = r_row;
                seg_req.y1 = r_row;
            end
            default: begin
                seg_req.x0 = r_ax;
            end
        endcase
    end

    assign sweep_req.valid = (r_state == mfb_pkg::T_FILL);
    assign sweep_req.ink   = r_ink;

    always_comb begin
        n_state      = r_state;
        n_eff_w      = r_eff_w;
        n_eff_h      = r_eff_h;
        n_mode       = r_mode;
        n_part       = r_part;
        n_ink        = r_ink;
        n_ax         = r_ax;
        n_ay         = r_ay;
        n_bx         = r_bx;
        n_by         = r_by;
        n_row        = r_row;
        n_pix        = r_pix;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_pix    = r_out_pix;
        n_out_status = r_out_status;

        // The user must write the configuration only while the engine is idle; the block does not enforce it.
        if (i_cfg_we) begin
            case (i_cfg_idx)
                mfb_pkg::CFG_IDX_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        n_eff_w = W_W'(1);
                    end else if (i_cfg_data > mfb_pkg::MAX_W) begin
                        n_eff_w = mfb_pkg::MAX_W;
                    end else begin
                        n_eff_w = i_cfg_data;
                    end
                end
                mfb_pkg::CFG_IDX_HEIGHT: begin
                    if (cfg_h == '0) begin
                        n_eff_h = H_W'(1);
                    end else if (cfg_h > mfb_pkg::MAX_H) begin
                        n_eff_h = mfb_pkg::MAX_H;
                    end else begin
                        n_eff_h = cfg_h;
                    end
                end
                default: begin
                    n_eff_w = r_eff_w;
                end
            endcase
        end

        case (r_state)
            mfb_pkg::T_IDLE: begin
                if (req_fire) begin
                    n_mode   = mfb_pkg::t_mode'(i_req.mode);
                    n_ink    = i_req.ink;
                    n_pix    = 1'b0;
                    n_status = 1'b0;
                    n_part   = mfb_pkg::EDGE_TOP;
                    case (mfb_pkg::t_mode'(i_req.mode))
                        mfb_pkg::MODE_PIXEL,
                        mfb_pkg::MODE_READ: begin
                            if (off_screen) begin
                                n_status = 1'b1;
                                n_state  = mfb_pkg::T_RESP;
                            end else begin
                                n_ax    = i_req.x_start[X_W-1:0];
                                n_ay    = i_req.y_start[Y_W-1:0];
                                n_bx    = i_req.x_start[X_W-1:0];
                                n_by    = i_req.y_start[Y_W-1:0];
                                n_state = mfb_pkg::T_SEG;
                            end
                        end
                        mfb_pkg::MODE_LINE: begin
                            n_ax    = cx0;
                            n_ay    = cy0;
                            n_bx    = cx1;
                            n_by    = cy1;
                            n_state = mfb_pkg::T_SEG;
                        end
                        mfb_pkg::MODE_RECT,
                        mfb_pkg::MODE_FILLED: begin
                            // A rectangle with no width or no height draws nothing.
                            if ((i_req.rect_width == '0) || (i_req.rect_height == '0)) begin
                                n_state = mfb_pkg::T_RESP;
                            end else begin
                                n_ax    = cx0;
                                n_ay    = cy0;
                                n_bx    = rx1;
                                n_by    = ry1;
                                n_row   = cy0;
                                n_state = mfb_pkg::T_SEG;
                            end
                        end
                        mfb_pkg::MODE_FILL: begin
                            n_state = mfb_pkg::T_FILL;
                        end
                        default: begin
                            n_state = mfb_pkg::T_RESP;
                        end
                    endcase
                end
            end
            mfb_pkg::T_SEG: begin
                if (seg_rsp.ready) begin
                    n_state = mfb_pkg::T_WAIT;
                end
            end
            mfb_pkg::T_WAIT: begin
                if (seg_rsp.done) begin
                    case (r_mode)
                        mfb_pkg::MODE_RECT: begin
                            if (r_part == mfb_pkg::EDGE_BOTTOM) begin
                                n_state = mfb_pkg::T_RESP;
                            end else begin
                                n_part  = mfb_pkg::t_edge'(r_part + 2'd1);
                                n_state = mfb_pkg::T_SEG;
                            end
                        end
                        mfb_pkg::MODE_FILLED: begin
                            if (r_row == r_by) begin
                                n_state = mfb_pkg::T_RESP;
                            end else begin
                                n_row   = r_row + Y_W'(1);
                                n_state = mfb_pkg::T_SEG;
                            end
                        end
                        mfb_pkg::MODE_READ: begin
                            n_pix   = seg_rsp.rd_bit;
                            n_state = mfb_pkg::T_RESP;
                        end
                        default: begin
                            n_state = mfb_pkg::T_RESP;
                        end
                    endcase
                end
            end
            mfb_pkg::T_FILL: begin
                if (pix_rsp.ready) begin
                    n_state = mfb_pkg::T_FILLW;
                end
            end
            mfb_pkg::T_FILLW: begin
                if (pix_rsp.done) begin
                    n_state = mfb_pkg::T_RESP;
                end
            end
            mfb_pkg::T_RESP: begin
                // The result waits here only while the output register still holds
                // a result that has not been taken.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_pix    = r_pix;
                    n_out_status = r_status;
                    n_state      = mfb_pkg::T_IDLE;
                end
            end
            default: begin
                n_state = mfb_pkg::T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfb_pkg::T_IDLE;
            r_eff_w     <= mfb_pkg::MAX_W;
            r_eff_h     <= mfb_pkg::MAX_H;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_eff_w     <= n_eff_w;
            r_eff_h     <= n_eff_h;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_part       <= n_part;
        r_ink        <= n_ink;
        r_ax         <= n_ax;
        r_ay         <= n_ay;
        r_bx         <= n_bx;
        r_by         <= n_by;
        r_row        <= n_row;
        r_pix        <= n_pix;
        r_status     <= n_status;
        r_out_pix    <= n_out_pix;
        r_out_status <= n_out_status;
    end

    // Bresenham stepper: walks one segment and issues one pixel access at a time.
    mfb_line_step u_line_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seg_req (seg_req),
        .o_seg_rsp (seg_rsp),
        .o_pix_req (pix_req),
        .i_pix_rsp (pix_rsp)
    );

    // Shared pixel unit: address arithmetic, frame store and store-wide sweeps.
    mfb_pix_unit #(
        .FB_WORD_BITS (FB_WORD_BITS),
        .FB_WORDS     (FB_WORDS)
    ) u_pix_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_w     (r_eff_w),
        .i_pix_req   (pix_req),
        .i_sweep_req (sweep_req),
        .o_pix_rsp   (pix_rsp)
    );

endmodule

// File: rtl/mfb_pix_unit.sv
module mfb_pix_unit #(
    parameter int FB_WORD_BITS = mfb_pkg::FB_WORD_BITS_DEF,
    parameter int FB_WORDS     = mfb_pkg::FB_WORDS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mfb_pkg::W_W-1:0]  i_eff_w,
    input  mfb_pkg::t_pix_req        i_pix_req,
    input  mfb_pkg::t_sweep_req      i_sweep_req,
    output mfb_pkg::t_pix_rsp        o_pix_rsp
);

    localparam int IDX_W = mfb_pkg::IDX_W;
    localparam int X_W   = mfb_pkg::X_W;
    localparam int Y_W   = mfb_pkg::Y_W;
    localparam int AW    = $clog2(FB_WORDS);
    localparam int BO_W  = $clog2(FB_WORD_BITS);

    // Word index by reciprocal multiplication: the estimate is at most one low,
    // and one compare-and-subtract fixes it.
    localparam int SHIFT = IDX_W + BO_W;
    localparam int M_W   = IDX_W + 1;
    localparam int P_W   = IDX_W + M_W;
    localparam logic [M_W-1:0]   RECIP  = M_W'((1 << SHIFT) / FB_WORD_BITS);
    localparam logic [IDX_W-1:0] DIV    = IDX_W'(FB_WORD_BITS);
    localparam logic [BO_W:0]    DIV_R  = (BO_W + 1)'(FB_WORD_BITS);
    localparam logic [31:0]      STORE_BITS = 32'(FB_WORDS * FB_WORD_BITS);

    mfb_pkg::t_px_state r_state, n_state;

    logic [FB_WORD_BITS-1:0] r_mem [FB_WORDS];
    logic [FB_WORD_BITS-1:0] r_word;

    logic [X_W-1:0]   r_x, n_x;
    logic [Y_W-1:0]   r_y, n_y;
    logic             r_ink, n_ink;
    logic             r_rd, n_rd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [P_W-1:0]   r_qm, n_qm;
    logic [IDX_W-1:0] r_q, n_q;
    logic [BO_W:0]    r_rem, n_rem;
    logic             r_ok, n_ok;
    logic [AW-1:0]    r_addr, n_addr;
    logic [BO_W-1:0]  r_bo, n_bo;
    logic             r_done, n_done;
    logic             r_bit, n_bit;
    logic [AW-1:0]    r_sweep, n_sweep;
    logic             r_fill, n_fill;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [FB_WORD_BITS-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;

    logic [IDX_W:0]   lin;
    logic [P_W-1:0]   qm_sh;
    logic [IDX_W-1:0] q_est;
    logic [IDX_W-1:0] qd;
    logic [IDX_W-1:0] rem;
    logic             cor;
    logic [IDX_W-1:0] q_fix;
    logic [BO_W:0]    bo_fix;

    assign lin    = (IDX_W + 1)'(i_eff_w) * (IDX_W + 1)'(r_y) + (IDX_W + 1)'(r_x);
    assign qm_sh  = r_qm >> SHIFT;
    assign q_est  = qm_sh[IDX_W-1:0];
    assign qd     = q_est * DIV;
    assign rem    = r_idx - qd;
    assign cor    = (r_rem >= DIV_R);
    assign q_fix  = cor ? (r_q + IDX_W'(1)) : r_q;
    assign bo_fix = cor ? (r_rem - DIV_R) : r_rem;

    assign o_pix_rsp.ready  = (r_state == mfb_pkg::PX_IDLE);
    assign o_pix_rsp.done   = r_done;
    assign o_pix_rsp.rd_bit = r_bit;

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_y       = r_y;
        n_ink     = r_ink;
        n_rd      = r_rd;
        n_idx     = r_idx;
        n_qm      = r_qm;
        n_q       = r_q;
        n_rem     = r_rem;
        n_ok      = r_ok;
        n_addr    = r_addr;
        n_bo      = r_bo;
        n_done    = 1'b0;
        n_bit     = r_bit;
        n_sweep   = r_sweep;
        n_fill    = r_fill;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_word;
        mem_re    = 1'b0;
        mem_raddr = q_fix[AW-1:0];
        case (r_state)
            mfb_pkg::PX_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = {FB_WORD_BITS{r_fill}};
                if (r_sweep == AW'(FB_WORDS - 1)) begin
                    n_state = mfb_pkg::PX_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            mfb_pkg::PX_IDLE: begin
                if (i_sweep_req.valid) begin
                    n_fill  = i_sweep_req.ink;
                    n_sweep = '0;
                    n_state = mfb_pkg::PX_SWEEP;
                end else if (i_pix_req.valid) begin
                    n_x     = i_pix_req.x;
                    n_y     = i_pix_req.y;
                    n_ink   = i_pix_req.ink;
                    n_rd    = i_pix_req.rd;
                    n_state = mfb_pkg::PX_IDX;
                end
            end
            mfb_pkg::PX_IDX: begin
                n_idx   = lin[IDX_W-1:0];
                n_state = mfb_pkg::PX_MUL;
            end
            mfb_pkg::PX_MUL: begin
                n_qm    = {{M_W{1'b0}}, r_idx} * {{IDX_W{1'b0}}, RECIP};
                n_state = mfb_pkg::PX_REM;
            end
            mfb_pkg::PX_REM: begin
                n_q     = q_est;
                n_rem   = rem[BO_W:0];
                n_ok    = ({{(32 - IDX_W){1'b0}}, r_idx} < STORE_BITS);
                n_state = mfb_pkg::PX_COR;
            end
            mfb_pkg::PX_COR: begin
                n_addr = q_fix[AW-1:0];
                n_bo   = bo_fix[BO_W-1:0];
                if (r_ok) begin
                    mem_re  = 1'b1;
                    n_state = mfb_pkg::PX_WR;
                end else begin
                    // Bits past the end of the store are neither written nor read.
                    n_bit   = 1'b0;
                    n_done  = 1'b1;
                    n_state = mfb_pkg::PX_IDLE;
                end
            end
            mfb_pkg::PX_WR: begin
                if (r_rd) begin
                    n_bit = r_word[r_bo];
                end else begin
                    mem_we          = 1'b1;
                    mem_wdata[r_bo] = r_ink;
                end
                n_done  = 1'b1;
                n_state = mfb_pkg::PX_IDLE;
            end
            default: begin
                n_state = mfb_pkg::PX_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfb_pkg::PX_SWEEP;
            r_done  <= 1'b0;
            r_sweep <= '0;
            r_fill  <= 1'b0;
            r_bit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_sweep <= n_sweep;
            r_fill  <= n_fill;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_ink  <= n_ink;
        r_rd   <= n_rd;
        r_idx  <= n_idx;
        r_qm   <= n_qm;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_ok   <= n_ok;
        r_addr <= n_addr;
        r_bo   <= n_bo;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_word <= r_mem[mem_raddr];
        end
    end

endmodule

// File: rtl/mfb_line_step.sv
module mfb_line_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mfb_pkg::t_seg_req    i_seg_req,
    output mfb_pkg::t_seg_rsp    o_seg_rsp,
    output mfb_pkg::t_pix_req    o_pix_req,
    input  mfb_pkg::t_pix_rsp    i_pix_rsp
);

    localparam int X_W   = mfb_pkg::X_W;
    localparam int Y_W   = mfb_pkg::Y_W;
    localparam int ERR_W = X_W + 3;

    mfb_pkg::t_ls_state r_state, n_state;

    logic [X_W-1:0]          r_x, n_x;
    logic [Y_W-1:0]          r_y, n_y;
    logic [X_W-1:0]          r_x1, n_x1;
    logic [Y_W-1:0]          r_y1, n_y1;
    logic [X_W-1:0]          r_dx, n_dx;
    logic [Y_W-1:0]          r_dy, n_dy;
    logic                    r_sx_neg, n_sx_neg;
    logic                    r_sy_neg, n_sy_neg;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic                    r_ink, n_ink;
    logic                    r_rd, n_rd;
    logic                    r_done, n_done;
    logic                    r_bit, n_bit;

    logic                    x_fwd;
    logic                    y_fwd;
    logic [X_W-1:0]          dx0;
    logic [Y_W-1:0]          dy0;
    logic signed [ERR_W-1:0] dxs;
    logic signed [ERR_W-1:0] dys;

    assign x_fwd = (i_seg_req.x0 < i_seg_req.x1);
    assign y_fwd = (i_seg_req.y0 < i_seg_req.y1);
    assign dx0   = x_fwd ? (i_seg_req.x1 - i_seg_req.x0) : (i_seg_req.x0 - i_seg_req.x1);
    assign dy0   = y_fwd ? (i_seg_req.y1 - i_seg_req.y0) : (i_seg_req.y0 - i_seg_req.y1);
    assign dxs   = $signed(ERR_W'(r_dx));
    assign dys   = $signed(ERR_W'(r_dy));

    assign o_seg_rsp.ready  = (r_state == mfb_pkg::LS_IDLE);
    assign o_seg_rsp.done   = r_done;
    assign o_seg_rsp.rd_bit = r_bit;

    assign o_pix_req.valid = (r_state == mfb_pkg::LS_ISSUE);
    assign o_pix_req.rd    = r_rd;
    assign o_pix_req.ink   = r_ink;
    assign o_pix_req.x     = r_x;
    assign o_pix_req.y     = r_y;

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_x1     = r_x1;
        n_y1     = r_y1;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_err    = r_err;
        n_ink    = r_ink;
        n_rd     = r_rd;
        n_done   = 1'b0;
        n_bit    = r_bit;
        case (r_state)
            mfb_pkg::LS_IDLE: begin
                if (i_seg_req.valid) begin
                    n_x      = i_seg_req.x0;
                    n_y      = i_seg_req.y0;
                    n_x1     = i_seg_req.x1;
                    n_y1     = i_seg_req.y1;
                    n_dx     = dx0;
                    n_dy     = dy0;
                    n_sx_neg = !x_fwd;
                    n_sy_neg = !y_fwd;
                    n_ink    = i_seg_req.ink;
                    n_rd     = i_seg_req.rd;
                    // Error starts at half the major delta, truncated toward zero, and negated when dy >= dx.
                    if (dx0 > X_W'(dy0)) begin
                        n_err = $signed(ERR_W'(dx0 >> 1));
                    end else begin
                        n_err = -$signed(ERR_W'(dy0 >> 1));
                    end
                    n_state = mfb_pkg::LS_ISSUE;
                end
            end
            mfb_pkg::LS_ISSUE: begin
                if (i_pix_rsp.ready) begin
                    n_state = mfb_pkg::LS_WAIT;
                end
            end
            mfb_pkg::LS_WAIT: begin
                if (i_pix_rsp.done) begin
                    n_bit = i_pix_rsp.rd_bit;
                    if ((r_x == r_x1) && (r_y == r_y1)) begin
                        n_done  = 1'b1;
                        n_state = mfb_pkg::LS_IDLE;
                    end else begin
                        if (r_err > -dxs) begin
                            n_err = n_err - dys;
                            n_x   = r_sx_neg ? (r_x - X_W'(1)) : (r_x + X_W'(1));
                        end
                        if (r_err < dys) begin
                            n_err = n_err + dxs;
                            n_y   = r_sy_neg ? (r_y - Y_W'(1)) : (r_y + Y_W'(1));
                        end
                        n_state = mfb_pkg::LS_ISSUE;
                    end
                end
            end
            default: begin
                n_state = mfb_pkg::LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfb_pkg::LS_IDLE;
            r_done  <= 1'b0;
            r_bit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_sx_neg <= n_sx_neg;
        r_sy_neg <= n_sy_neg;
        r_err    <= n_err;
        r_ink    <= n_ink;
        r_rd     <= n_rd;
    end

endmodule
